>>> rtl/bmd_pkg.sv
// Shared types and constants for the button multipress detector.
// No dependencies; the evaluation logic and the top level import it.
`default_nettype none

package bmd_pkg;

	localparam int TIME_WIDTH = 32;
	localparam int NUM_BTN    = 4;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int IN_W       = 40;
	localparam int OUT_W      = 8;
	localparam int CNT_W      = 3;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd20;
	localparam logic [CFG_W-1:0] DOUBLE_WIN_RST = 16'd350;
	localparam logic [CFG_W-1:0] TRIPLE_WIN_RST = 16'd600;

	typedef enum logic [2:0] {
		EV_B1_PRESS  = 3'd0,
		EV_B1_DOUBLE = 3'd1,
		EV_B2_PRESS  = 3'd2,
		EV_B3_PRESS  = 3'd3,
		EV_B4_PRESS  = 3'd4,
		EV_B4_DOUBLE = 3'd5,
		EV_B4_TRIPLE = 3'd6
	} event_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE   = 2'd0,
		REG_DOUBLE_WIN = 2'd1,
		REG_TRIPLE_WIN = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [CFG_W-1:0] debounce;
		logic [CFG_W-1:0] dbl_win;
		logic [CFG_W-1:0] tpl_win;
	} cfg_t;

	typedef struct packed {
		logic [NUM_BTN-1:0]                 prev;
		logic [NUM_BTN-1:0][TIME_WIDTH-1:0] start;
		logic [1:0]                         c1_cnt;
		logic [TIME_WIDTH-1:0]              c1_time;
		logic [1:0]                         c4_cnt;
		logic [TIME_WIDTH-1:0]              c4_time;
	} state_t;

	typedef struct packed {
		event_code_t [NUM_BTN-1:0] codes;
		logic [CNT_W-1:0]          n;
	} batch_t;

endpackage

`default_nettype wire

>>> rtl/bmd_eval.sv
// Per-sample evaluation: edge detection, hold check and click chaining.
// Pure combinational logic; depends on bmd_pkg.
`default_nettype none

module bmd_eval
	import bmd_pkg::*;
(
	input  wire logic [NUM_BTN-1:0]    levels,
	input  wire logic [TIME_WIDTH-1:0] time_ms,
	input  wire state_t                cur,
	input  wire cfg_t                  cfg,
	output state_t                     nxt,
	output batch_t                     batch
);

	always_comb begin
		logic [NUM_BTN-1:0]    click;
		logic [TIME_WIDTH-1:0] el;
		logic [TIME_WIDTH-1:0] el1;
		logic [TIME_WIDTH-1:0] el4;
		logic [1:0]            cnt1;
		logic [1:0]            cnt4;
		event_code_t           evs [NUM_BTN];
		logic [CNT_W-1:0]      n;

		nxt   = cur;
		click = '0;
		for (int i = 0; i < NUM_BTN; i++) begin
			el = time_ms - cur.start[i];
			if (levels[i] && !cur.prev[i]) begin
				nxt.start[i] = time_ms;
			end else if (!levels[i] && cur.prev[i]) begin
				click[i] = (el >= TIME_WIDTH'(cfg.debounce));
			end
			nxt.prev[i] = levels[i];
		end

		// button one: single or double, count clears after a double
		el1  = time_ms - cur.c1_time;
		cnt1 = (el1 < TIME_WIDTH'(cfg.dbl_win)) ? cur.c1_cnt + 2'd1 : 2'd1;
		if (cnt1 >= 2'd2) begin
			evs[0] = EV_B1_DOUBLE;
		end else begin
			evs[0] = EV_B1_PRESS;
		end
		if (click[0]) begin
			nxt.c1_time = time_ms;
			nxt.c1_cnt  = (cnt1 >= 2'd2) ? 2'd0 : cnt1;
		end

		evs[1] = EV_B2_PRESS;
		evs[2] = EV_B3_PRESS;

		// button four: count is kept after a double, clears after a triple
		el4  = time_ms - cur.c4_time;
		cnt4 = (el4 < TIME_WIDTH'(cfg.tpl_win)) ? cur.c4_cnt + 2'd1 : 2'd1;
		if (cnt4 >= 2'd3) begin
			evs[3] = EV_B4_TRIPLE;
		end else if (cnt4 == 2'd2) begin
			evs[3] = EV_B4_DOUBLE;
		end else begin
			evs[3] = EV_B4_PRESS;
		end
		if (click[3]) begin
			nxt.c4_time = time_ms;
			nxt.c4_cnt  = (cnt4 >= 2'd3) ? 2'd0 : cnt4;
		end

		// pack clicks in button order
		n = '0;
		for (int i = 0; i < NUM_BTN; i++) begin
			batch.codes[i] = EV_B1_PRESS;
		end
		for (int i = 0; i < NUM_BTN; i++) begin
			if (click[i]) begin
				batch.codes[n[1:0]] = evs[i];
				n = n + CNT_W'(1);
			end
		end
		batch.n = n;
	end

endmodule

`default_nettype wire

>>> rtl/button_multipress_detector.sv
// Button multipress detector: top level with sample register and result buffer.
// Depends on bmd_pkg and bmd_eval.
//
// Input stream (s_axis): one poll sample per item, tdata = buttons_pressed in
// bits 3:0, time_ms in bits 35:4, zero pad to 40 bits.
// Output stream (m_axis): one click per item, tdata bits 2:0 = event_code,
// tlast = final click caused by that sample. A sample with no click gives no
// item at all.
// Configuration: cfg_we/cfg_index/cfg_wdata write the debounce, double window
// and triple window registers; indexes above the list are dropped. Write only
// while the block is idle.
// A sample accepted on s_axis is registered in the sample register, evaluated, and
// its clicks loaded into the result buffer once the buffer is free; the first
// click shows from then on. A sample that causes no click never waits on the buffer;
// a sample with n clicks (up to 4) holds the single output port until all have left,
// and the next sample is evaluated in the cycle the last click leaves.
// Reset clears the button levels, press times, click counters and timers to
// zero and restores the register defaults (20, 350, 600 ms).
// A stalled receiver holds the current click; a following sample with clicks then
// waits in the sample register and s_axis_tready drops until the buffer frees up.
`default_nettype none

module button_multipress_detector
	import bmd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [IN_W-1:0]      s_axis_tdata,   // [3:0] buttons_pressed, [35:4] time_ms
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [OUT_W-1:0]          m_axis_tdata,   // [2:0] event_code
	output logic                      m_axis_tlast,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata
);

	logic                  valid_s1;
	logic [NUM_BTN-1:0]    levels_s1;
	logic [TIME_WIDTH-1:0] time_s1;
	state_t                state_q;
	state_t                state_nxt;
	cfg_t                  cfg_q;
	batch_t                batch_e;
	batch_t                batch_q;
	logic                  bvalid_q;
	logic [1:0]            idx_q;
	logic                  s_fire;
	logic                  m_fire;
	logic                  last;
	logic                  batch_free;
	logic                  advance;
	logic                  load;

	bmd_eval u_eval (
		.levels  (levels_s1),
		.time_ms (time_s1),
		.cur     (state_q),
		.cfg     (cfg_q),
		.nxt     (state_nxt),
		.batch   (batch_e)
	);

	assign s_fire     = s_axis_tvalid && s_axis_tready;
	assign m_fire     = m_axis_tvalid && m_axis_tready;
	assign last       = ({1'b0, idx_q} + CNT_W'(1)) == batch_q.n;
	assign batch_free = !bvalid_q || (m_fire && last);
	// samples without clicks only touch state, so they never wait on the buffer
	assign advance    = valid_s1 && ((batch_e.n == '0) || batch_free);
	assign load       = advance && (batch_e.n != '0);

	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = bvalid_q;
	assign m_axis_tdata  = OUT_W'(batch_q.codes[idx_q]);
	assign m_axis_tlast  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{debounce: DEBOUNCE_RST, dbl_win: DOUBLE_WIN_RST,
				tpl_win: TRIPLE_WIN_RST};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEBOUNCE:   cfg_q.debounce <= cfg_wdata;
				REG_DOUBLE_WIN: cfg_q.dbl_win  <= cfg_wdata;
				REG_TRIPLE_WIN: cfg_q.tpl_win  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			levels_s1 <= s_axis_tdata[NUM_BTN-1:0];
			time_s1   <= s_axis_tdata[NUM_BTN +: TIME_WIDTH];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvalid_q <= 1'b0;
			idx_q    <= '0;
			batch_q  <= '0;
		end else if (load) begin
			bvalid_q <= 1'b1;
			idx_q    <= '0;
			batch_q  <= batch_e;
		end else if (m_fire) begin
			if (last) begin
				bvalid_q <= 1'b0;
			end
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

`default_nettype wire

>>> rtl/bmd_checker.sv
// Port-level checker for the button multipress detector, bound to the top.
// Depends on bmd_pkg.
`default_nettype none

module bmd_port_checker
	import bmd_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             m_axis_tvalid,
	input wire logic             m_axis_tready,
	input wire logic [OUT_W-1:0] m_axis_tdata,
	input wire logic             m_axis_tlast
);

	logic m_fire;
	assign m_fire = m_axis_tvalid && m_axis_tready;

	// stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output item changed while stalled");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[2:0] <= EV_B4_TRIPLE))
		else $error("event code out of range");

	// a run continues without a gap until tlast
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_fire && !m_axis_tlast |=> m_axis_tvalid)
		else $error("run broken before tlast");

	// clicks of one sample come in button order
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_fire && !m_axis_tlast |=> m_axis_tdata[2:0] > $past(m_axis_tdata[2:0]))
		else $error("clicks out of button order");

endmodule

bind button_multipress_detector bmd_port_checker u_bmd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

>>> sim/bmd_checker.sv
// Scoreboard for the button multipress detector: watches the sample, click and
// register-write channels, predicts the clicks of each sample and checks them in order.
// Depends on bmd_pkg only.
module bmd_checker
	import bmd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	input  wire logic                 s_axis_tready,
	input  wire logic [IN_W-1:0]      s_axis_tdata,   // [3:0] buttons_pressed, [35:4] time_ms
	input  wire logic                 m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	input  wire logic [OUT_W-1:0]     m_axis_tdata,   // [2:0] event_code
	input  wire logic                 m_axis_tlast,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	output int                        mismatches,
	output int                        clicks_pending,
	output int                        clicks_checked
);

	typedef struct packed {
		event_code_t code;
		logic        last;
	} click_t;

	click_t clicks_due[$];

	logic [CFG_W-1:0]      hold_min;
	logic [CFG_W-1:0]      b1_window;
	logic [CFG_W-1:0]      b4_window;
	logic [NUM_BTN-1:0]    held;
	logic [TIME_WIDTH-1:0] down_at [NUM_BTN];
	logic [1:0]            b1_count;
	logic [1:0]            b4_count;
	logic [TIME_WIDTH-1:0] b1_last;
	logic [TIME_WIDTH-1:0] b4_last;

	initial begin
		mismatches     = 0;
		clicks_pending = 0;
		clicks_checked = 0;
	end

	function automatic void report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10) begin
			$display("MISMATCH at %0t: %s", $time, msg);
		end
	endfunction

	// Advance the click chain of one button and name the click it forms.
	function automatic event_code_t classify_click(input int btn, input logic [TIME_WIDTH-1:0] t);
		event_code_t           code;
		logic [TIME_WIDTH-1:0] gap;
		case (btn)
			0: begin
				gap = t - b1_last;
				if (gap < b1_window) b1_count = b1_count + 2'd1;
				else b1_count = 2'd1;
				b1_last = t;
				if (b1_count >= 2'd2) begin
					b1_count = 2'd0;
					code     = EV_B1_DOUBLE;
				end else begin
					code = EV_B1_PRESS;
				end
			end
			1: code = EV_B2_PRESS;
			2: code = EV_B3_PRESS;
			default: begin
				gap = t - b4_last;
				if (gap < b4_window) b4_count = b4_count + 2'd1;
				else b4_count = 2'd1;
				b4_last = t;
				// keep the count after a double so a third click makes a triple
				if (b4_count == 2'd3) begin
					b4_count = 2'd0;
					code     = EV_B4_TRIPLE;
				end else if (b4_count == 2'd2) begin
					code = EV_B4_DOUBLE;
				end else begin
					code = EV_B4_PRESS;
				end
			end
		endcase
		return code;
	endfunction

	task automatic predict_sample(input logic [IN_W-1:0] item);
		logic [NUM_BTN-1:0]    now_held;
		logic [TIME_WIDTH-1:0] t;
		logic [TIME_WIDTH-1:0] hold;
		event_code_t           batch [NUM_BTN];
		int                    n;
		now_held = item[NUM_BTN-1:0];
		t        = item[NUM_BTN +: TIME_WIDTH];
		n        = 0;
		for (int i = 0; i < NUM_BTN; i++) begin
			hold = t - down_at[i];
			if (now_held[i] && !held[i]) begin
				down_at[i] = t;
			end else if (!now_held[i] && held[i] && hold >= hold_min) begin
				batch[n] = classify_click(i, t);
				n++;
			end
		end
		held = now_held;
		for (int k = 0; k < n; k++) begin
			clicks_due.push_back(click_t'{batch[k], k == n - 1});
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		click_t want;
		if (!arst_n) begin
			hold_min  = DEBOUNCE_RST;
			b1_window = DOUBLE_WIN_RST;
			b4_window = TRIPLE_WIN_RST;
			held      = '0;
			for (int i = 0; i < NUM_BTN; i++) down_at[i] = '0;
			b1_count = '0;
			b4_count = '0;
			b1_last  = '0;
			b4_last  = '0;
			clicks_due.delete();
		end else begin
			// check before predicting: a click never leaves in the edge its sample enters
			if (m_axis_tvalid && m_axis_tready) begin
				if (clicks_due.size() == 0) begin
					report_mismatch($sformatf("unexpected click, code %0d last %0b",
						m_axis_tdata[2:0], m_axis_tlast));
				end else begin
					want = clicks_due.pop_front();
					clicks_checked++;
					if (m_axis_tdata[2:0] != want.code) begin
						report_mismatch($sformatf("event_code expected %0d got %0d",
							want.code, m_axis_tdata[2:0]));
					end
					if (m_axis_tlast != want.last) begin
						report_mismatch($sformatf("last flag expected %0b got %0b",
							want.last, m_axis_tlast));
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_DEBOUNCE:   hold_min  = cfg_wdata;
					REG_DOUBLE_WIN: b1_window = cfg_wdata;
					REG_TRIPLE_WIN: b4_window = cfg_wdata;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) predict_sample(s_axis_tdata);
		end
		clicks_pending = clicks_due.size();
	end

endmodule

>>> sim/tb_button_multipress_detector.sv
// Testbench top for the button multipress detector: clock, reset, sample and
// register stimulus, receiver pacing, watchdog and verdict.
// Depends on bmd_pkg, bmd_checker and the button_multipress_detector RTL.
module tb_button_multipress_detector;
	import bmd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int QUIET_LIMIT   = 4000;
	localparam int PHASE_SAMPLES = 21;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [IN_W-1:0]      s_axis_tdata;   // [3:0] buttons_pressed, [35:4] time_ms
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [OUT_W-1:0]     m_axis_tdata;   // [2:0] event_code
	logic                 m_axis_tlast;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	int mismatches;
	int clicks_pending;
	int clicks_checked;

	int                    src_idle_pct;
	int                    sink_stall_pct;
	int                    quiet_cycles;
	int                    samples_sent;
	int                    settings_used;
	int                    hold_cfg;
	int                    dbl_cfg;
	int                    tpl_cfg;
	logic [NUM_BTN-1:0]    levels;
	logic [TIME_WIDTH-1:0] now_ms;

	button_multipress_detector u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	bmd_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tlast   (m_axis_tlast),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.mismatches     (mismatches),
		.clicks_pending (clicks_pending),
		.clicks_checked (clicks_checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	// Count cycles in which neither stream moves an item.
	always @(posedge clk) begin
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
			$display("Some tests failed");
			$finish;
		end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Returns at the rising edge that accepts the item; valid stays up for a follow-on item.
	task automatic send_sample(input logic [NUM_BTN-1:0] btn, input logic [TIME_WIDTH-1:0] t);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0000, t, btn};
		do @(posedge clk); while (!s_axis_tready);
		levels = btn;
		now_ms = t;
		samples_sent++;
	endtask

	// Hold the sender until every predicted click has left the block.
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (clicks_pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic load_regs(input logic [CFG_W-1:0] debounce, input logic [CFG_W-1:0] dbl_win,
			input logic [CFG_W-1:0] tpl_win);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_DEBOUNCE;
		cfg_wdata <= debounce;
		@(negedge clk);
		cfg_index <= REG_DOUBLE_WIN;
		cfg_wdata <= dbl_win;
		@(negedge clk);
		cfg_index <= REG_TRIPLE_WIN;
		cfg_wdata <= tpl_win;
		// the spare index must leave all registers alone
		@(negedge clk);
		cfg_index <= REG_SPARE;
		cfg_wdata <= CFG_W'($urandom);
		@(negedge clk);
		cfg_we <= 1'b0;
		hold_cfg = int'(debounce);
		dbl_cfg  = int'(dbl_win);
		tpl_cfg  = int'(tpl_win);
		settings_used++;
	endtask

	// Toggle a few buttons after a time step sized around the hold time or the windows, or a random step.
	task automatic random_sample();
		logic [NUM_BTN-1:0]    flip;
		logic [TIME_WIDTH-1:0] step;
		int                    pick;
		int                    win_span;
		win_span = ((dbl_cfg > tpl_cfg) ? dbl_cfg : tpl_cfg) + 20;
		pick     = $urandom_range(0, 19);
		if (pick == 0) step = $urandom;
		else if (pick < 9) step = $urandom_range(0, 2 * hold_cfg + 2);
		else step = $urandom_range(0, win_span);
		case ($urandom_range(0, 9))
			0: flip = NUM_BTN'($urandom_range(0, 15));
			1, 2: flip = (4'b0001 << $urandom_range(0, 3)) | (4'b0001 << $urandom_range(0, 3));
			default: flip = 4'b0001 << $urandom_range(0, 3);
		endcase
		send_sample(levels ^ flip, now_ms + step);
	endtask

	initial begin
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		cfg_we         = 1'b0;
		cfg_index      = REG_DEBOUNCE;
		cfg_wdata      = '0;
		arst_n         = 1'b0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		samples_sent   = 0;
		settings_used  = 1;
		hold_cfg       = int'(DEBOUNCE_RST);
		dbl_cfg        = int'(DOUBLE_WIN_RST);
		tpl_cfg        = int'(TRIPLE_WIN_RST);
		levels         = '0;
		now_ms         = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part on the reset register values.
		send_sample(4'b0000, 32'd0);
		send_sample(4'b0001, 32'd10);
		send_sample(4'b0000, 32'd40);          // first click chains onto the zero timer: single
		send_sample(4'b0001, 32'd100);
		send_sample(4'b0000, 32'd110);         // held too briefly: nothing
		send_sample(4'b0001, 32'd200);
		send_sample(4'b0000, 32'd230);         // button one double
		send_sample(4'b1111, 32'd300);
		send_sample(4'b0000, 32'd400);         // four clicks, last flag on button four
		send_sample(4'b1000, 32'd500);
		send_sample(4'b0000, 32'd550);         // button four double
		send_sample(4'b1000, 32'd600);
		send_sample(4'b0000, 32'd650);         // button four triple
		send_sample(4'b0110, 32'd700);
		send_sample(4'b0110, 32'd720);         // no edge
		send_sample(4'b0100, 32'd719);         // time steps back: hold below debounce
		send_sample(4'b1001, 32'hFFFF_FFF0);
		send_sample(4'b0000, 32'h0000_0010);   // hold spans the timestamp wrap
		send_sample(4'b0000, 32'hFFFF_FFFF);
		drain();

		// Zero debounce and zero windows: an instant release counts, nothing chains.
		load_regs(16'd0, 16'd0, 16'd0);
		send_sample(4'b0101, 32'd5000);
		send_sample(4'b0000, 32'd5000);
		send_sample(4'b0001, 32'd5000);
		send_sample(4'b0000, 32'd5000);
		drain();

		// Largest values: a hold of exactly the debounce time counts.
		load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_sample(4'b1000, 32'd10000);
		send_sample(4'b0000, 32'd75535);
		drain();

		// Random part, one register setting and pacing mix per phase.
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					src_idle_pct   = 0;
					sink_stall_pct = 0;
					load_regs(DEBOUNCE_RST, DOUBLE_WIN_RST, TRIPLE_WIN_RST);
				end
				1: begin
					src_idle_pct   = 50;
					sink_stall_pct = 0;
					load_regs(16'd0, 16'hFFFF, 16'hFFFF);
				end
				2: begin
					src_idle_pct   = 0;
					sink_stall_pct = 50;
					load_regs(CFG_W'($urandom_range(5, 60)), CFG_W'($urandom_range(100, 400)),
						CFG_W'($urandom_range(200, 800)));
				end
				default: begin
					src_idle_pct   = 23;
					sink_stall_pct = 23;
					load_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
				end
			endcase
			for (int k = 0; k < PHASE_SAMPLES; k++) begin
				random_sample();
				if ($urandom_range(0, 24) == 0) drain();
			end
			drain();
		end

		repeat (8) @(negedge clk);
		$display("Sent %0d samples under %0d register settings and four pacing mixes;",
			samples_sent, settings_used);
		$display("checked %0d clicks in order with their last flags.", clicks_checked);
		if (mismatches == 0 && clicks_pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
